[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the key mapper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An assertion on an explicit clock and active-low reset.
`define LPKM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An assertion on the block clock and reset.
`define LPKM_ASSERT(lbl, prop, msg) `LPKM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/lpkm_pkg.sv]
// ----------------------------------------------------------------------------
// Key mapper package
// Field widths, payload types and command and status codes.
// ----------------------------------------------------------------------------
package lpkm_pkg;

  localparam int KEY_W  = 16;
  localparam int MOD_W  = 3;
  localparam int CODE_W = 16;
  localparam int SLOT_W = 7;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [MOD_W-1:0]  mod_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SET    = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

endpackage

[src/lpkm_req_if.sv]
// ----------------------------------------------------------------------------
// Key mapper request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface lpkm_req_if;
  logic               valid;
  logic               ready;
  lpkm_pkg::cmd_e     cmd;
  lpkm_pkg::key_t     key;
  lpkm_pkg::mod_t     modifiers;
  lpkm_pkg::code_t    code_value;

  modport source (output valid, cmd, key, modifiers, code_value, input ready);
  modport sink (input valid, cmd, key, modifiers, code_value, output ready);
endinterface

[src/lpkm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Key mapper response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface lpkm_rsp_if;
  logic               valid;
  logic               ready;
  lpkm_pkg::status_e  status;
  lpkm_pkg::slot_t    slot;
  lpkm_pkg::code_t    mapped_code;

  modport source (output valid, status, slot, mapped_code, input ready);
  modport sink (input valid, status, slot, mapped_code, output ready);
endinterface

[src/linear_probe_key_mapper_core.sv]
// ----------------------------------------------------------------------------
// Linear probe key mapper
// Open-addressing hash table with linear probing that maps keys to codes.
// ----------------------------------------------------------------------------
// The block works on one item at a time. Each probed slot is read from the
// key memory in S_PROBE and the entry is checked in S_CHECK; a look-up hit
// then reads the code memory in S_CRD and gives its result in S_COUT. A
// clear walks the key memory one slot a cycle. After reset a clearing pass
// zeroes the code memory and empties the key memory, and no item is
// accepted until it ends. A finished result waits in the output register
// while the next item is taken in.
module linear_probe_key_mapper_core #(
  parameter int SLOTS      = 128,
  parameter int KEY_BITS   = 16,
  parameter int CODE_BITS  = 16,
  parameter int MOD_COMBOS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lpkm_req_if.sink           req_i,
  lpkm_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  lpkm_pkg::code_t    cfg_wdata_i
);

  localparam int SW     = $clog2(SLOTS);
  localparam int KW     = (KEY_BITS < lpkm_pkg::KEY_W) ? KEY_BITS : lpkm_pkg::KEY_W;
  localparam int CW     = (CODE_BITS < lpkm_pkg::CODE_W) ? CODE_BITS : lpkm_pkg::CODE_W;
  localparam int MW     = (MOD_COMBOS > 1) ? $clog2(MOD_COMBOS) : 1;
  localparam int RW     = lpkm_pkg::MOD_W + 2;
  localparam int DEPTH  = SLOTS * MOD_COMBOS;
  localparam int AW     = $clog2(DEPTH);
  localparam int OSW    = lpkm_pkg::SLOT_W;
  localparam int OCW    = lpkm_pkg::CODE_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_COUT  = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;

  function automatic logic [MW-1:0] mod_index(input lpkm_pkg::mod_t m);
    logic [RW-1:0] r;
    r = RW'(m);
    for (int i = 0; i < 8; i++) begin
      if (r >= RW'(MOD_COMBOS)) begin
        r = r - RW'(MOD_COMBOS);
      end
    end
    return MW'(r);
  endfunction

  logic [2:0]        state_q, state_d;
  logic [SW-1:0]     p_q, p_d;
  logic [SW-1:0]     n_q, n_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  lpkm_pkg::cmd_e    cmd_q, cmd_d;
  logic [KW-1:0]     k_q, k_d;
  logic [MW-1:0]     mod_q, mod_d;
  logic [CW-1:0]     val_q, val_d;
  lpkm_pkg::code_t   none_q;
  logic              out_valid_q, out_valid_d;
  lpkm_pkg::status_e out_status_q, out_status_d;
  lpkm_pkg::slot_t   out_slot_q, out_slot_d;
  lpkm_pkg::code_t   out_code_q, out_code_d;

  logic [KW:0]       key_mem [SLOTS];
  logic [CW-1:0]     code_mem [DEPTH];
  logic [KW:0]       key_rd_q;
  logic [CW-1:0]     code_rd_q;

  logic              key_we;
  logic [SW-1:0]     key_waddr;
  logic [KW:0]       key_wdata;
  logic              code_we;
  logic [AW-1:0]     code_waddr;
  logic [CW-1:0]     code_wdata;
  logic [AW-1:0]     caddr;

  logic              slot_used, key_hit, last_probe, out_free;
  logic              fin;
  lpkm_pkg::status_e fin_status;
  lpkm_pkg::slot_t   fin_slot;
  lpkm_pkg::code_t   fin_code;

  assign slot_used  = key_rd_q[KW];
  assign key_hit    = slot_used && (key_rd_q[KW-1:0] == k_q);
  assign last_probe = (n_q == LAST_SLOT);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign caddr      = AW'(p_q) * AW'(MOD_COMBOS) + AW'(mod_q);

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.mapped_code = out_code_q;

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    k_d          = k_q;
    mod_d        = mod_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_code_d   = out_code_q;
    key_we       = 1'b0;
    key_waddr    = p_q;
    key_wdata    = {1'b1, k_q};
    code_we      = 1'b0;
    code_waddr   = caddr;
    code_wdata   = val_q;
    fin          = 1'b0;
    fin_status   = lpkm_pkg::ST_OK;
    fin_slot     = '0;
    fin_code     = '0;

    case (state_q)
      S_INIT: begin
        key_we     = 1'b1;
        key_waddr  = cnt_q[SW-1:0];
        key_wdata  = {1'b0, k_q};
        code_we    = 1'b1;
        code_waddr = cnt_q;
        code_wdata = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d   = req_i.cmd;
          k_d     = req_i.key[KW-1:0];
          mod_d   = mod_index(req_i.modifiers);
          val_d   = req_i.code_value[CW-1:0];
          p_d     = SW'(req_i.key[KW-1:0]);
          n_d     = '0;
          cnt_d   = '0;
          state_d = (req_i.cmd == lpkm_pkg::CMD_CLEAR) ? S_CLR : S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_q == lpkm_pkg::CMD_INSERT) begin
          if (!slot_used) begin
            fin      = out_free;
            key_we   = out_free;
            fin_slot = OSW'(p_q);
          end else if (last_probe) begin
            fin        = out_free;
            fin_status = lpkm_pkg::ST_FULL;
          end else begin
            p_d     = p_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = S_PROBE;
          end
        end else begin
          if (key_hit) begin
            if (cmd_q == lpkm_pkg::CMD_SET) begin
              fin      = out_free;
              code_we  = out_free;
              fin_slot = OSW'(p_q);
              fin_code = OCW'(val_q);
            end else begin
              state_d = S_CRD;
            end
          end else if (!slot_used || last_probe) begin
            fin        = out_free;
            fin_status = lpkm_pkg::ST_NOT_FOUND;
            fin_code   = none_q;
          end else begin
            p_d     = p_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = S_PROBE;
          end
        end
      end
      S_CRD: begin
        state_d = S_COUT;
      end
      S_COUT: begin
        fin      = out_free;
        fin_slot = OSW'(p_q);
        fin_code = OCW'(code_rd_q);
      end
      S_CLR: begin
        key_we    = 1'b1;
        key_waddr = cnt_q[SW-1:0];
        key_wdata = {1'b0, k_q};
        if (cnt_q[SW-1:0] == LAST_SLOT) begin
          fin = out_free;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d      = S_IDLE;
      out_valid_d  = 1'b1;
      out_status_d = fin_status;
      out_slot_d   = fin_slot;
      out_code_d   = fin_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      none_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        none_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    n_q          <= n_d;
    cmd_q        <= cmd_d;
    k_q          <= k_d;
    mod_q        <= mod_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_code_q   <= out_code_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (state_q == S_PROBE) begin
      key_rd_q <= key_mem[p_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    if (state_q == S_CRD) begin
      code_rd_q <= code_mem[caddr];
    end
  end

endmodule

[src/lpkm_checker.sv]
// ----------------------------------------------------------------------------
// Key mapper checker
// Port-level assertions on the key mapper, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpkm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [1:0]      rsp_status_i,
  input lpkm_pkg::slot_t rsp_slot_i,
  input lpkm_pkg::code_t rsp_code_i
);

  `LPKM_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_slot_i) && $stable(rsp_code_i), "stalled result item changed")
  `LPKM_ASSERT(a_accept_busy, req_valid_i && req_ready_i |=> !req_ready_i, "item accepted while busy")
  `LPKM_ASSERT(a_full_zero, rsp_valid_i && rsp_status_i == lpkm_pkg::ST_FULL |-> rsp_slot_i == '0 && rsp_code_i == '0, "full result carries data")
  `LPKM_ASSERT(a_miss_slot, rsp_valid_i && rsp_status_i == lpkm_pkg::ST_NOT_FOUND |-> rsp_slot_i == '0, "miss result carries a slot")

endmodule

bind linear_probe_key_mapper_core lpkm_checker u_lpkm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_code_i   (rsp_o.mapped_code)
);
